>>> src/albp_pkg.sv
// alarm led and buzzer pattern: shared types and constants
// no dependencies
package albp_pkg;

    // width of the millisecond time base by default
    localparam int TIME_BITS_DEFAULT = 32;

    // configuration register defaults
    localparam logic [15:0] LINK_BLINK_RESET   = 16'd500;
    localparam logic [15:0] ERROR_BLINK_RESET  = 16'd600;
    localparam logic [15:0] CRIT_TOGGLE_RESET  = 16'd300;
    localparam logic [15:0] CHIRP_INTVL_RESET  = 16'd10000;
    localparam logic [15:0] CHIRP_LENGTH_RESET = 16'd80;

    // register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_LINK_BLINK   = 3'd0,
        REG_ERROR_BLINK  = 3'd1,
        REG_CRIT_TOGGLE  = 3'd2,
        REG_CHIRP_INTVL  = 3'd3,
        REG_CHIRP_LENGTH = 3'd4
    } reg_index_t;

    // status codes carried by an update
    localparam logic [1:0] STATUS_NORMAL   = 2'd0;
    localparam logic [1:0] STATUS_WARNING  = 2'd1;
    localparam logic [1:0] STATUS_CRITICAL = 2'd2;
    localparam logic [1:0] STATUS_SENSOR   = 2'd3;

    // alarm mode chosen per update
    typedef enum logic [2:0] {
        MODE_NORMAL   = 3'd0,
        MODE_WARNING  = 3'd1,
        MODE_CRITICAL = 3'd2,
        MODE_SENSOR   = 3'd3,
        MODE_LINKDOWN = 3'd4
    } mode_t;

    // lamp bits: bit0 green, bit1 yellow, bit2 red
    typedef logic [2:0] lamps_t;
    localparam lamps_t LAMP_OFF    = 3'b000;
    localparam lamps_t LAMP_GREEN  = 3'b001;
    localparam lamps_t LAMP_YELLOW = 3'b010;
    localparam lamps_t LAMP_RED    = 3'b100;

endpackage

>>> src/alarm_led_buzzer_pattern_core.sv
// Path: an accepted word waits in the input register and moves into the result register,
// which drives m_tvalid, when that register is empty or m_tready takes its word.
// Throughput: one word per cycle while m_tready is high; one input register, one result
// register; pattern state (stamps, phase, lamp, buzzer levels) updates once per word.
// Reset: aresetn is synchronous, active low; it clears both valid flags, all pattern
// state to zero and the five period registers to their default values.
module alarm_led_buzzer_pattern_core
    import albp_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [0] reading_valid, [2:1] status_code, [3] link_up,
                                   // [35:4] now_ms, [39:36] zero
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] led_green, [1] led_yellow, [2] led_red,
                                   // [3] buzzer, [7:4] zero
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [15:0] link_blink_reg;
    logic [15:0] error_blink_reg;
    logic [15:0] crit_toggle_reg;
    logic [15:0] chirp_intvl_reg;
    logic [15:0] chirp_length_reg;

    logic       cfg_write;
    reg_index_t cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    // word addressed registers; low address bits ignored
    assign cfg_index = reg_index_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_blink_reg   <= LINK_BLINK_RESET;
            error_blink_reg  <= ERROR_BLINK_RESET;
            crit_toggle_reg  <= CRIT_TOGGLE_RESET;
            chirp_intvl_reg  <= CHIRP_INTVL_RESET;
            chirp_length_reg <= CHIRP_LENGTH_RESET;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_LINK_BLINK:   link_blink_reg   <= pwdata[15:0];
                REG_ERROR_BLINK:  error_blink_reg  <= pwdata[15:0];
                REG_CRIT_TOGGLE:  crit_toggle_reg  <= pwdata[15:0];
                REG_CHIRP_INTVL:  chirp_intvl_reg  <= pwdata[15:0];
                REG_CHIRP_LENGTH: chirp_length_reg <= pwdata[15:0];
                default: ;  // addresses past the list are ignored
            endcase
        end
    end

    // read back, unused addresses read zero
    always_comb begin
        case (cfg_index)
            REG_LINK_BLINK:   prdata = {16'd0, link_blink_reg};
            REG_ERROR_BLINK:  prdata = {16'd0, error_blink_reg};
            REG_CRIT_TOGGLE:  prdata = {16'd0, crit_toggle_reg};
            REG_CHIRP_INTVL:  prdata = {16'd0, chirp_intvl_reg};
            REG_CHIRP_LENGTH: prdata = {16'd0, chirp_length_reg};
            default:          prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------
    // input register
    // ---------------------------------------------------------------
    logic        in_valid_reg;
    logic        reading_valid_reg;
    logic [1:0]  status_code_reg;
    logic        link_up_reg;
    logic [31:0] now_ms_reg;

    logic out_valid_reg;
    logic advance;     // input register moves into the result register

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    // the input register frees up in the same cycle its word moves on
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            reading_valid_reg <= s_tdata[0];
            status_code_reg   <= s_tdata[2:1];
            link_up_reg       <= s_tdata[3];
            now_ms_reg        <= s_tdata[35:4];
        end
    end

    // ---------------------------------------------------------------
    // pattern state
    // ---------------------------------------------------------------
    logic [TIME_BITS-1:0] blink_stamp_reg, blink_stamp_next;
    logic [TIME_BITS-1:0] toggle_stamp_reg, toggle_stamp_next;
    logic [TIME_BITS-1:0] chirp_stamp_reg, chirp_stamp_next;
    logic                 blink_phase_reg, blink_phase_next;
    logic                 buzzer_level_reg, buzzer_level_next;
    lamps_t               lamp_levels_reg, lamp_levels_next;
    logic                 chirp_active_reg, chirp_active_next;

    logic [TIME_BITS-1:0] now_w;
    logic [TIME_BITS-1:0] since_blink;
    logic [TIME_BITS-1:0] since_toggle;
    logic [TIME_BITS-1:0] since_chirp;
    mode_t                mode;
    logic                 chirp_end;
    logic                 blink_phase_flip;

    // time base is cut or zero extended to TIME_BITS, then all elapsed
    // times are wrapping differences
    assign now_w        = TIME_BITS'(now_ms_reg);
    assign since_blink  = now_w - blink_stamp_reg;
    assign since_toggle = now_w - toggle_stamp_reg;
    assign since_chirp  = now_w - chirp_stamp_reg;
    assign blink_phase_flip = !blink_phase_reg;

    // mode priority: sensor error, link down, then status code
    always_comb begin
        if (!reading_valid_reg || status_code_reg == STATUS_SENSOR) begin
            mode = MODE_SENSOR;
        end else if (!link_up_reg) begin
            mode = MODE_LINKDOWN;
        end else begin
            case (status_code_reg)
                STATUS_WARNING:  mode = MODE_WARNING;
                STATUS_CRITICAL: mode = MODE_CRITICAL;
                default:         mode = MODE_NORMAL;
            endcase
        end
    end

    // a sounding chirp stops when warning mode is left or its length is up
    assign chirp_end = chirp_active_reg &&
                       (mode != MODE_WARNING ||
                        since_chirp >= TIME_BITS'(chirp_length_reg));

    always_comb begin
        blink_stamp_next  = blink_stamp_reg;
        toggle_stamp_next = toggle_stamp_reg;
        chirp_stamp_next  = chirp_stamp_reg;
        blink_phase_next  = blink_phase_reg;
        lamp_levels_next  = lamp_levels_reg;
        chirp_active_next = chirp_end ? 1'b0 : chirp_active_reg;
        buzzer_level_next = chirp_end ? 1'b0 : buzzer_level_reg;

        case (mode)
            MODE_SENSOR: begin
                // red and buzzer blink together
                if (since_blink >= TIME_BITS'(error_blink_reg)) begin
                    blink_stamp_next  = now_w;
                    blink_phase_next  = blink_phase_flip;
                    lamp_levels_next  = blink_phase_flip ? LAMP_RED : LAMP_OFF;
                    buzzer_level_next = blink_phase_flip;
                end
            end
            MODE_LINKDOWN: begin
                if (since_blink >= TIME_BITS'(link_blink_reg)) begin
                    blink_stamp_next = now_w;
                    blink_phase_next = blink_phase_flip;
                    lamp_levels_next = blink_phase_flip ? LAMP_YELLOW : LAMP_OFF;
                end
                buzzer_level_next = 1'b0;
            end
            MODE_CRITICAL: begin
                lamp_levels_next = LAMP_RED;
                if (since_toggle >= TIME_BITS'(crit_toggle_reg)) begin
                    toggle_stamp_next = now_w;
                    buzzer_level_next = !buzzer_level_next;
                end
            end
            MODE_WARNING: begin
                lamp_levels_next = LAMP_YELLOW;
                if (since_chirp >= TIME_BITS'(chirp_intvl_reg)) begin
                    chirp_stamp_next  = now_w;
                    chirp_active_next = 1'b1;
                    buzzer_level_next = 1'b1;
                end
            end
            default: begin
                lamp_levels_next  = LAMP_GREEN;
                buzzer_level_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blink_stamp_reg  <= '0;
            toggle_stamp_reg <= '0;
            chirp_stamp_reg  <= '0;
            blink_phase_reg  <= 1'b0;
            buzzer_level_reg <= 1'b0;
            lamp_levels_reg  <= LAMP_OFF;
            chirp_active_reg <= 1'b0;
        end else if (advance) begin
            blink_stamp_reg  <= blink_stamp_next;
            toggle_stamp_reg <= toggle_stamp_next;
            chirp_stamp_reg  <= chirp_stamp_next;
            blink_phase_reg  <= blink_phase_next;
            buzzer_level_reg <= buzzer_level_next;
            lamp_levels_reg  <= lamp_levels_next;
            chirp_active_reg <= chirp_active_next;
        end
    end

    // ---------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------
    logic [3:0] out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {buzzer_level_next, lamp_levels_next};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_data_reg};

endmodule
